### rtl/blpdf_pkg.sv
// Shared types and codes for the bounded list push/delete/find unit.
package blpdf_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned LEN_W    = 9;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CMD_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_DELETE     = 2'd2,
		CMD_FIND       = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   position;
		logic [LEN_W-1:0]   list_length;
	} res_t;

endpackage

### rtl/blpdf_ram.sv
// Simple dual-port entry store with one write port and a registered read port.
module blpdf_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/blpdf_ctrl.sv
// Command sequencer: pointers, list walk and gap closing over the entry store.
module blpdf_ctrl #(
	parameter int unsigned CAPACITY = 256,
	parameter int unsigned AW       = 8,
	parameter int unsigned CW       = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  blpdf_pkg::cmd_t      in_cmd,
	input  logic signed [31:0]   in_value,
	output logic                 res_valid,
	input  logic                 res_ready,
	output blpdf_pkg::res_t      res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [31:0]          mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [31:0]          mem_rdata
);

	import blpdf_pkg::*;

	state_t             state_q, state_d;
	logic [AW-1:0]      head_q, head_d;
	logic [CW-1:0]      count_q, count_d;

	cmd_t               cmd_q, cmd_d;
	logic signed [31:0] value_q, value_d;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [CW-1:0]      k_q, k_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	status_t            status_q, status_d;

	logic [AW-1:0]      next_ptr;
	logic [AW-1:0]      head_dec;
	logic [CW-1:0]      k_inc;
	logic [CW:0]        back_sum;
	logic [CW:0]        back_slot;
	logic               full;
	logic [CW+POS_W-1:0] k_ext;
	logic [CW+LEN_W-1:0] count_ext;

	assign next_ptr  = (ptr_q == AW'(CAPACITY - 1)) ? '0 : ptr_q + 1'b1;
	assign head_dec  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
	assign k_inc     = k_q + 1'b1;
	assign back_sum  = {1'b0, count_q} + (CW+1)'(head_q);
	assign back_slot = (back_sum >= (CW+1)'(CAPACITY)) ?
		back_sum - (CW+1)'(CAPACITY) : back_sum;
	assign full      = (count_q == CW'(CAPACITY));
	assign k_ext     = {{POS_W{1'b0}}, k_q};
	assign count_ext = {{LEN_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		value_q  <= value_d;
		ptr_q    <= ptr_d;
		k_q      <= k_d;
		pos_q    <= pos_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		cmd_d     = cmd_q;
		value_d   = value_q;
		ptr_d     = ptr_q;
		k_d       = k_q;
		pos_d     = pos_q;
		status_d  = status_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = in_value;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_d    = in_cmd;
					value_d  = in_value;
					pos_d    = '0;
					status_d = ST_OK;
					state_d  = S_DONE;
					case (in_cmd)
						CMD_PUSH_FRONT: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = head_dec;
								head_d    = head_dec;
								count_d   = count_q + 1'b1;
							end
						end
						CMD_PUSH_BACK: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = back_slot[AW-1:0];
								count_d   = count_q + 1'b1;
							end
						end
						default: begin
							// Delete and find both walk the list from the front.
							if (count_q == '0) begin
								status_d = ST_NOTFOUND;
							end else begin
								ptr_d   = head_q;
								k_d     = '0;
								state_d = S_SCAN_RD;
							end
						end
					endcase
				end
			end
			S_SCAN_RD: begin
				mem_re  = 1'b1;
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (mem_rdata == value_q) begin
					if (cmd_q == CMD_FIND) begin
						pos_d   = k_ext[POS_W-1:0];
						state_d = S_DONE;
					end else if (k_inc < count_q) begin
						state_d = S_SHIFT_RD;
					end else begin
						count_d = count_q - 1'b1;
						state_d = S_DONE;
					end
				end else if (k_inc == count_q) begin
					status_d = ST_NOTFOUND;
					state_d  = S_DONE;
				end else begin
					ptr_d   = next_ptr;
					k_d     = k_inc;
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				// Fetch the successor of the slot being overwritten.
				mem_re    = 1'b1;
				mem_raddr = next_ptr;
				state_d   = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = mem_rdata;
				ptr_d     = next_ptr;
				k_d       = k_inc;
				if (k_inc + 1'b1 < count_q) begin
					state_d = S_SHIFT_RD;
				end else begin
					count_d = count_q - 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.status      = status_q;
	assign res.position    = pos_q;
	assign res.list_length = count_ext[LEN_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(CAPACITY - 1))
		else $error("head pointer outside the store");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("read and write of one entry in the same cycle");

	a_full_only_push: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == ST_FULL)) |->
			((cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK)))
		else $error("full status on a command that does not push");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_WR) |-> ($past(state_q) == S_SHIFT_RD))
		else $error("shift write without a preceding read");

endmodule

### rtl/bounded_list_push_delete_find_unit.sv
// Top level of the bounded list unit: stream ports, entry store and result register.
//
//   Channel | Dir | Handshake          | Contents
//   --------+-----+--------------------+---------------------------------------------
//   s_      | in  | s_tvalid/s_tready  | tuser: cmd[1:0]; tdata: value[31:0]
//   m_      | out | m_tvalid/m_tready  | tuser: status[1:0]; tdata: position, length
//
// A push, and a delete or find on an empty list, goes from acceptance straight to the
// done state, from which its result enters the output register.
// A find reads and compares the entries in turn from the front until a match or
// the end of the list. A delete walks to the match and then closes the gap with
// one read and one write per moved entry. The pace is set by the single read port
// of the entry store and its registered read data. One item is in work at a time;
// the next item is taken while the previous result still waits in the output
// register.
// Reset clears the state, the head pointer, the count and the output valid flag;
// the store needs no clearing pass since only live entries are ever read.
module bounded_list_push_delete_find_unit #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value (signed)
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] position, [16:8] list_length, [23:17] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	import blpdf_pkg::*;

	// Address and count widths follow from the capacity; the count must hold
	// the capacity itself.
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	logic          res_valid;
	logic          res_ready;
	res_t          res;

	// Output register: holds a finished result until the consumer takes it.
	logic          m_tvalid_q;
	res_t          res_q;

	blpdf_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	blpdf_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_value  (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// A new result may enter when the register is empty or is drained this cycle.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, res_q.list_length, res_q.position};
	assign m_tuser  = res_q.status;

endmodule
